@@ rtl/tlca_pkg.sv @@
// tlca_pkg: shared constants for the lowest common ancestor engine
// field widths, item kind codes and default sizes; no dependencies
`default_nettype none

package tlca_pkg;

  // fixed field widths
  localparam int NODE_W = 10;
  localparam int KIND_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // default sizes
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_LEVELS    = 11;
  localparam int DEF_MAX_EDGES = 2048;

  // register reset
  localparam logic [NODE_W-1:0] ROOT_RESET = 10'd1;

endpackage

`default_nettype wire

@@ rtl/tree_lca_binary_lifting.sv @@
// tree_lca_binary_lifting: tree lca engine with adjacency store, bfs build
// and binary lifting query; depends on tlca_pkg
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------
//   input    | in        | in_valid/in_stall  | kind, node_a, node_b
//   result   | out       | out_valid/out_stall| ancestor_node
//   config   | in        | apb psel/penable   | root_node at byte address 0
//
// after reset a clearing pass over all MAX_NODES entries runs while in_stall
// is high. an edge transfer steps through states S_E1 to S_E4, a query steps
// through the levels, set by the single read port of the ancestor and depth
// memories used twice per level. a build walks each adjacency entry and reached node.
// in_stall is high while an item is in work; a finished result waits in the
// output register, so a new item is taken while out_stall holds the result.
`default_nettype none

module tree_lca_binary_lifting #(
  parameter int MAX_NODES = tlca_pkg::DEF_MAX_NODES,
  parameter int LEVELS    = tlca_pkg::DEF_LEVELS,
  parameter int MAX_EDGES = tlca_pkg::DEF_MAX_EDGES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [tlca_pkg::KIND_W-1:0]  kind,
  input  wire logic [tlca_pkg::NODE_W-1:0]  node_a,
  input  wire logic [tlca_pkg::NODE_W-1:0]  node_b,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tlca_pkg::NODE_W-1:0]       ancestor_node,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import tlca_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int DW = $clog2(MAX_NODES + 1);
  localparam int QW = $clog2(MAX_NODES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int LW = $clog2(LEVELS);

  typedef logic [LEVELS-1:0][NW-1:0] row_t;

  // sequencer codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_E1     = 5'd2;
  localparam logic [4:0] S_E2     = 5'd3;
  localparam logic [4:0] S_E3     = 5'd4;
  localparam logic [4:0] S_E4     = 5'd5;
  localparam logic [4:0] S_BINIT  = 5'd6;
  localparam logic [4:0] S_BPOP   = 5'd7;
  localparam logic [4:0] S_BHEAD1 = 5'd8;
  localparam logic [4:0] S_BHEAD2 = 5'd9;
  localparam logic [4:0] S_BEDGE  = 5'd10;
  localparam logic [4:0] S_BTGT   = 5'd11;
  localparam logic [4:0] S_BCHK   = 5'd12;
  localparam logic [4:0] S_BANC1  = 5'd13;
  localparam logic [4:0] S_BANC2  = 5'd14;
  localparam logic [4:0] S_BWR    = 5'd15;
  localparam logic [4:0] S_QDA    = 5'd16;
  localparam logic [4:0] S_QDB    = 5'd17;
  localparam logic [4:0] S_QSW    = 5'd18;
  localparam logic [4:0] S_QL1    = 5'd19;
  localparam logic [4:0] S_QL2    = 5'd20;
  localparam logic [4:0] S_QL3    = 5'd21;
  localparam logic [4:0] S_QEQ    = 5'd22;
  localparam logic [4:0] S_QM1    = 5'd23;
  localparam logic [4:0] S_QM2    = 5'd24;
  localparam logic [4:0] S_QM3    = 5'd25;
  localparam logic [4:0] S_QF1    = 5'd26;
  localparam logic [4:0] S_QF2    = 5'd27;
  localparam logic [4:0] S_QOUT   = 5'd28;

  // memories
  logic [EW-1:0] head_mem  [MAX_NODES];
  logic [DW-1:0] depth_mem [MAX_NODES];
  row_t          anc_mem   [MAX_NODES];
  logic [NW-1:0] wq_mem    [MAX_NODES];
  logic [NW-1:0] etgt_mem  [MAX_EDGES];
  logic [EW-1:0] enxt_mem  [MAX_EDGES];

  // control and working registers
  logic [4:0]        state;
  logic [NW-1:0]     clr_idx;
  logic              built;
  logic [NODE_W-1:0] root_node;
  logic [EW-1:0]     edge_count;
  logic [NW-1:0]     qa, qb, p_node, pa, res;
  logic [DW-1:0]     da, dx;
  logic [LW-1:0]     lvl;
  logic [NW-1:0]     cur, x_node, y_node;
  logic [EW-1:0]     e_ptr;
  row_t              rowbuf;
  logic [QW-1:0]     rd_ptr, wr_ptr;

  // read data
  logic [EW-1:0] head_q;
  logic [DW-1:0] depth_q;
  row_t          anc_q;
  logic [NW-1:0] wq_q;
  logic [NW-1:0] etgt_q;
  logic [EW-1:0] enxt_q;

  // memory port controls
  logic [NW-1:0] head_raddr, depth_raddr, anc_raddr, wq_raddr;
  logic [EW-1:0] edge_raddr;
  logic          head_we, depth_we, anc_we, wq_we, edge_we;
  logic [NW-1:0] head_waddr, depth_waddr, anc_waddr, wq_waddr;
  logic [EW-1:0] edge_waddr;
  logic [EW-1:0] head_wdata, enxt_wdata;
  logic [DW-1:0] depth_wdata;
  row_t          anc_wdata;
  logic [NW-1:0] wq_wdata, etgt_wdata;

  // decoded input
  logic          in_xfer, a_ok, b_ok, root_ok, store_full, out_free;
  logic [NW-1:0] a_nw, b_nw, root_nw, anc_lvl, anc_prev;

  assign in_xfer  = in_valid && !in_stall;
  assign a_ok     = (32'(node_a) < 32'(MAX_NODES));
  assign b_ok     = (32'(node_b) < 32'(MAX_NODES));
  assign root_ok  = (root_node != '0) && (32'(root_node) < 32'(MAX_NODES));
  assign a_nw     = a_ok ? NW'(node_a) : '0;
  assign b_nw     = b_ok ? NW'(node_b) : '0;
  assign root_nw  = NW'(root_node);
  assign store_full = (32'(edge_count) + 32'd2) > 32'(MAX_EDGES - 1);
  assign anc_lvl  = anc_q[lvl];
  assign anc_prev = anc_q[LW'(lvl - 1'b1)];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(root_node) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= ROOT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      root_node <= pwdata[NODE_W-1:0];
    end
  end

  // memory address and write selection
  always_comb begin
    head_raddr  = qa;
    depth_raddr = qa;
    anc_raddr   = qa;
    wq_raddr    = NW'(rd_ptr);
    edge_raddr  = e_ptr;
    head_we     = 1'b0;
    depth_we    = 1'b0;
    anc_we      = 1'b0;
    wq_we       = 1'b0;
    edge_we     = 1'b0;
    head_waddr  = qa;
    depth_waddr = y_node;
    anc_waddr   = y_node;
    wq_waddr    = NW'(wr_ptr);
    edge_waddr  = edge_count + 1'b1;
    head_wdata  = edge_count + 1'b1;
    enxt_wdata  = head_q;
    etgt_wdata  = qb;
    depth_wdata = dx + 1'b1;
    anc_wdata   = rowbuf;
    wq_wdata    = y_node;
    case (state)
      S_CLR: begin
        head_we     = 1'b1;
        depth_we    = 1'b1;
        anc_we      = 1'b1;
        head_waddr  = clr_idx;
        depth_waddr = clr_idx;
        anc_waddr   = clr_idx;
        head_wdata  = '0;
        depth_wdata = '0;
        anc_wdata   = '0;
      end
      S_E1: head_raddr = qa;
      S_E2: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      S_E3: head_raddr = qb;
      S_E4: begin
        head_we    = 1'b1;
        edge_we    = 1'b1;
        head_waddr = qb;
        edge_waddr = edge_count + EW'(2);
        head_wdata = edge_count + EW'(2);
        etgt_wdata = qa;
      end
      S_BINIT: begin
        depth_we    = 1'b1;
        depth_waddr = root_nw;
        depth_wdata = DW'(1);
        wq_we       = 1'b1;
        wq_waddr    = '0;
        wq_wdata    = root_nw;
      end
      S_BHEAD1: begin
        head_raddr  = wq_q;
        depth_raddr = wq_q;
      end
      S_BTGT: depth_raddr = etgt_q;
      S_BCHK: depth_we = (depth_q == '0);
      S_BANC1: anc_raddr = cur;
      S_BWR: begin
        anc_we = 1'b1;
        wq_we  = (32'(wr_ptr) < 32'(MAX_NODES));
      end
      S_QDA: depth_raddr = qa;
      S_QDB: depth_raddr = qb;
      S_QL1: anc_raddr = qb;
      S_QL2: depth_raddr = anc_lvl;
      S_QM1: anc_raddr = qa;
      S_QM2: anc_raddr = qb;
      S_QF1: anc_raddr = qa;
      default: ;
    endcase
  end

  // memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (depth_we) depth_mem[depth_waddr] <= depth_wdata;
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    if (wq_we) wq_mem[wq_waddr] <= wq_wdata;
    if (edge_we) begin
      etgt_mem[edge_waddr] <= etgt_wdata;
      enxt_mem[edge_waddr] <= enxt_wdata;
    end
    head_q  <= head_mem[head_raddr];
    depth_q <= depth_mem[depth_raddr];
    anc_q   <= anc_mem[anc_raddr];
    wq_q    <= wq_mem[wq_raddr];
    etgt_q  <= etgt_mem[edge_raddr];
    enxt_q  <= enxt_mem[edge_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      built      <= 1'b0;
      edge_count <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (clr_idx == NW'(MAX_NODES - 1)) state <= S_IDLE;
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (in_xfer) begin
            qa <= a_nw;
            qb <= b_nw;
            case (kind)
              KIND_EDGE: begin
                if (!built && a_ok && b_ok && node_a != '0 && node_b != '0 &&
                    !store_full) state <= S_E1;
              end
              KIND_BUILD: begin
                if (!built) begin
                  built <= 1'b1;
                  if (root_ok) state <= S_BINIT;
                end
              end
              KIND_QUERY: begin
                if (built) begin
                  state <= S_QDA;
                end else begin
                  res   <= '0;
                  state <= S_QOUT;
                end
              end
              default: ;
            endcase
          end
        end
        // edge insert, one directed entry at a time
        S_E1: state <= S_E2;
        S_E2: state <= S_E3;
        S_E3: state <= S_E4;
        S_E4: begin
          edge_count <= edge_count + EW'(2);
          state      <= S_IDLE;
        end
        // breadth first walk
        S_BINIT: begin
          rd_ptr <= '0;
          wr_ptr <= QW'(1);
          state  <= S_BPOP;
        end
        S_BPOP: begin
          if (rd_ptr == wr_ptr) begin
            state <= S_IDLE;
          end else begin
            rd_ptr <= rd_ptr + 1'b1;
            state  <= S_BHEAD1;
          end
        end
        S_BHEAD1: begin
          x_node <= wq_q;
          state  <= S_BHEAD2;
        end
        S_BHEAD2: begin
          e_ptr <= head_q;
          dx    <= depth_q;
          state <= S_BEDGE;
        end
        S_BEDGE: state <= (e_ptr == '0) ? S_BPOP : S_BTGT;
        S_BTGT: begin
          y_node <= etgt_q;
          e_ptr  <= enxt_q;
          state  <= S_BCHK;
        end
        S_BCHK: begin
          if (depth_q != '0) begin
            state <= S_BEDGE;
          end else begin
            rowbuf[0] <= x_node;
            cur       <= x_node;
            lvl       <= LW'(1);
            state     <= S_BANC1;
          end
        end
        S_BANC1: state <= S_BANC2;
        S_BANC2: begin
          rowbuf[lvl] <= anc_prev;
          cur         <= anc_prev;
          if (lvl == LW'(LEVELS - 1)) begin
            state <= S_BWR;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= S_BANC1;
          end
        end
        S_BWR: begin
          if (32'(wr_ptr) < 32'(MAX_NODES)) wr_ptr <= wr_ptr + 1'b1;
          state <= S_BEDGE;
        end
        // query: depths, then lift the deeper node
        S_QDA: state <= S_QDB;
        S_QDB: begin
          da    <= depth_q;
          state <= S_QSW;
        end
        S_QSW: begin
          if (da > depth_q) begin
            qa <= qb;
            qb <= qa;
            da <= depth_q;
          end
          lvl   <= LW'(LEVELS - 1);
          state <= S_QL1;
        end
        S_QL1: state <= S_QL2;
        S_QL2: begin
          p_node <= anc_lvl;
          state  <= S_QL3;
        end
        S_QL3: begin
          if (depth_q >= da) qb <= p_node;
          if (lvl == '0) begin
            state <= S_QEQ;
          end else begin
            lvl   <= lvl - 1'b1;
            state <= S_QL1;
          end
        end
        S_QEQ: begin
          if (qa == qb) begin
            res   <= qa;
            state <= S_QOUT;
          end else begin
            lvl   <= LW'(LEVELS - 1);
            state <= S_QM1;
          end
        end
        // lift both while ancestors differ
        S_QM1: state <= S_QM2;
        S_QM2: begin
          pa    <= anc_lvl;
          state <= S_QM3;
        end
        S_QM3: begin
          if (pa != anc_lvl) begin
            qa <= pa;
            qb <= anc_lvl;
          end
          if (lvl == '0) begin
            state <= S_QF1;
          end else begin
            lvl   <= lvl - 1'b1;
            state <= S_QM1;
          end
        end
        S_QF1: state <= S_QF2;
        S_QF2: begin
          res   <= anc_q[0];
          state <= S_QOUT;
        end
        S_QOUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, one transfer per query
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_QOUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_QOUT && out_free) ancestor_node <= NODE_W'(res);
  end

endmodule

`default_nettype wire
